/* hdl/c2dsp_pkg.sv */
// shared types and constants for the 2d convolution block
// no dependencies; imported by every module of the block but c2dsp_ram
package c2dsp_pkg;

  localparam int MAX_HEIGHT   = 32;
  localparam int MAX_WIDTH    = 32;
  localparam int MAX_CHANNELS = 1024;

  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CHAN_W     = $clog2(MAX_CHANNELS);
  localparam int ACC_ADDR_W = ROW_W + COL_W;
  localparam int ACC_DEPTH  = 1 << ACC_ADDR_W;

  localparam int HEIGHT_W   = 6;
  localparam int WIDTH_W    = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int MODE_W    = 2;
  localparam int TAP_IDX_W = 4;
  localparam int VALUE_W   = 32;
  localparam int PIX_W     = 16;
  localparam int SUM_W     = 48;
  localparam int PROD_W    = 32;
  localparam int PSUM_W    = 34;
  localparam int WSUM_W    = 36;
  localparam int TAPS      = 9;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIXEL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd3;

  // win[i][j]: i = row (0 oldest), j = column (0 oldest)
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

  // one pixel's worth of work; omask bits: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
  typedef struct packed {
    window_t          win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       omask;
    logic             last;
    logic             emit;
    logic             first;
    logic             k1x1;
  } job_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               busy;
  } bstat_t;

  typedef struct packed {
    logic [ACC_ADDR_W-1:0] addr;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  first;
    logic                  emit;
    logic                  last;
  } meta_t;

endpackage

/* hdl/c2dsp_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module c2dsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when read and write hit the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/c2dsp_front.sv */
// front end: config registers, taps, bias, raster positions, line buffers, window
// depends on c2dsp_pkg and c2dsp_ram; hands one job per useful pixel to the queue
module c2dsp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [c2dsp_pkg::MODE_W-1:0]         mode,
  input  logic [c2dsp_pkg::TAP_IDX_W-1:0]      tap_index,
  input  logic [c2dsp_pkg::VALUE_W-1:0]        value,
  input  logic                                 cfg_write,
  input  logic [c2dsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c2dsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  c2dsp_pkg::bstat_t                    bstat,
  output logic                                 push,
  output c2dsp_pkg::job_t                      push_job,
  output c2dsp_pkg::taps_t                     taps,
  output logic [c2dsp_pkg::VALUE_W-1:0]        bias
);
  import c2dsp_pkg::*;

  logic [HEIGHT_W-1:0]   height_reg;
  logic [WIDTH_W-1:0]    width_reg;
  logic                  k3_reg;
  logic [CFG_DATA_W-1:0] chans_reg;

  logic [ROW_W-1:0]  h_m1;
  logic [COL_W-1:0]  w_m1;
  logic [CHAN_W-1:0] ch_m1;

  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic [CHAN_W-1:0] chan_pos;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic              emit;
  logic [3:0]        omask;

  logic             acc;
  logic             pix_acc;
  logic             drained;
  logic [Q_CNT_W:0] fill;
  logic             room;

  logic             f1_valid;
  logic [PIX_W-1:0] f1_pix;
  logic [ROW_W-1:0] f1_row;
  logic [COL_W-1:0] f1_col;
  logic [3:0]       f1_mask;
  logic             f1_last;
  logic             f1_emit;
  logic             f1_first;
  logic             f1_k1x1;
  logic             f1_par;
  logic             f1_ok0;
  logic             f1_ok1;

  logic [MAX_WIDTH-1:0] line0_ok;
  logic [MAX_WIDTH-1:0] line1_ok;

  logic [PIX_W-1:0] line0_rd;
  logic [PIX_W-1:0] line1_rd;
  logic [PIX_W-1:0] line0_px;
  logic [PIX_W-1:0] line1_px;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  window_t          window;
  window_t          window_next;

  // sizes out of range saturate
  always_comb begin
    if (height_reg == '0) begin
      h_m1 = '0;
    end else if (height_reg > HEIGHT_W'(MAX_HEIGHT)) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(height_reg - 1'b1);
    end
    if (width_reg == '0) begin
      w_m1 = '0;
    end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(width_reg - 1'b1);
    end
    if (chans_reg == '0) begin
      ch_m1 = '0;
    end else if (chans_reg > CFG_DATA_W'(MAX_CHANNELS)) begin
      ch_m1 = CHAN_W'(MAX_CHANNELS - 1);
    end else begin
      ch_m1 = CHAN_W'(chans_reg - 1'b1);
    end
  end

  // positions left beyond a shrunk plane restart at zero
  assign r    = (row_pos > h_m1) ? '0 : row_pos;
  assign c    = (col_pos > w_m1) ? '0 : col_pos;
  assign emit = (chan_pos >= ch_m1);

  always_comb begin
    if (!k3_reg) begin
      omask = 4'b1000;
    end else begin
      omask[0] = (r != '0) && (c != '0);
      omask[1] = (r != '0) && (c == w_m1);
      omask[2] = (r == h_m1) && (c != '0);
      omask[3] = (r == h_m1) && (c == w_m1);
    end
  end

  assign drained = !f1_valid && (bstat.count == '0) && !bstat.busy;
  assign fill    = {1'b0, bstat.count} + {{Q_CNT_W{1'b0}}, f1_valid};
  assign room    = fill < (Q_CNT_W + 1)'(Q_DEPTH);

  // weights and bias wait for the back end to drain
  always_comb begin
    unique case (mode) inside
      MODE_WEIGHT, MODE_BIAS: in_stall = !drained;
      MODE_PIXEL:             in_stall = !room;
      default:                in_stall = 1'b0;
    endcase
  end

  assign acc     = in_valid && !in_stall;
  assign pix_acc = acc && (mode == MODE_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      height_reg <= HEIGHT_W'(MAX_HEIGHT);
      width_reg  <= WIDTH_W'(MAX_WIDTH);
      k3_reg     <= 1'b1;
      chans_reg  <= CFG_DATA_W'(1);
      taps       <= '0;
      bias       <= '0;
      row_pos    <= '0;
      col_pos    <= '0;
      chan_pos   <= '0;
      f1_valid   <= 1'b0;
      line0_ok   <= '0;
      line1_ok   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_HEIGHT:   height_reg <= cfg_data[HEIGHT_W-1:0];
          CFG_WIDTH:    width_reg  <= cfg_data[WIDTH_W-1:0];
          CFG_KERNEL:   k3_reg     <= cfg_data[0];
          CFG_CHANNELS: chans_reg  <= cfg_data;
          default: ;
        endcase
      end
      f1_valid <= pix_acc;
      if (acc) begin
        unique case (mode)
          MODE_WEIGHT: begin
            if (tap_index <= TAP_IDX_W'(TAPS - 1)) begin
              taps[tap_index] <= value[PIX_W-1:0];
            end
          end
          MODE_BIAS: begin
            bias     <= value;
            row_pos  <= '0;
            col_pos  <= '0;
            chan_pos <= '0;
          end
          MODE_PIXEL: begin
            // line words never written since reset read as zero
            if (r[0]) begin
              line1_ok[c] <= 1'b1;
            end else begin
              line0_ok[c] <= 1'b1;
            end
            if (c == w_m1) begin
              col_pos <= '0;
              if (r == h_m1) begin
                row_pos  <= '0;
                chan_pos <= emit ? '0 : chan_pos + 1'b1;
              end else begin
                row_pos <= r + 1'b1;
              end
            end else begin
              col_pos <= c + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      f1_pix   <= value[PIX_W-1:0];
      f1_row   <= r;
      f1_col   <= c;
      f1_mask  <= omask;
      f1_last  <= (r == h_m1) && (c == w_m1);
      f1_emit  <= emit;
      f1_first <= (chan_pos == '0);
      f1_k1x1  <= !k3_reg;
      f1_par   <= r[0];
      f1_ok0   <= line0_ok[c];
      f1_ok1   <= line1_ok[c];
    end
    if (f1_valid) begin
      window <= window_next;
    end
  end

  // one line buffer per row parity, both read at the current column
  c2dsp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (pix_acc && !r[0]),
    .waddr (c),
    .wdata (value[PIX_W-1:0]),
    .re    (pix_acc),
    .raddr (c),
    .rdata (line0_rd)
  );

  c2dsp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (pix_acc && r[0]),
    .waddr (c),
    .wdata (value[PIX_W-1:0]),
    .re    (pix_acc),
    .raddr (c),
    .rdata (line1_rd)
  );

  assign line0_px = f1_ok0 ? line0_rd : '0;
  assign line1_px = f1_ok1 ? line1_rd : '0;
  assign top      = f1_par ? line1_px : line0_px;
  assign mid      = f1_par ? line0_px : line1_px;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      window_next[i][0] = window[i][1];
      window_next[i][1] = window[i][2];
    end
    window_next[0][2] = top;
    window_next[1][2] = mid;
    window_next[2][2] = f1_pix;
  end

  assign push           = f1_valid && (f1_mask != '0);
  assign push_job.win   = window_next;
  assign push_job.row   = f1_row;
  assign push_job.col   = f1_col;
  assign push_job.omask = f1_mask;
  assign push_job.last  = f1_last;
  assign push_job.emit  = f1_emit;
  assign push_job.first = f1_first;
  assign push_job.k1x1  = f1_k1x1;

endmodule

/* hdl/c2dsp_queue.sv */
// short job queue between front and back end
// depends on c2dsp_pkg
module c2dsp_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  c2dsp_pkg::job_t                 push_job,
  input  logic                            pop,
  output c2dsp_pkg::job_t                 head,
  output logic [c2dsp_pkg::Q_CNT_W-1:0]   count
);
  import c2dsp_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign head = slots[rd_ptr];

endmodule

/* hdl/c2dsp_back.sv */
// back end: mul, add tree, accumulate; one output per cycle unless stalled
// depends on c2dsp_pkg and c2dsp_ram; owns the accumulator plane
module c2dsp_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  c2dsp_pkg::job_t                       head,
  input  logic [c2dsp_pkg::Q_CNT_W-1:0]         q_count,
  input  c2dsp_pkg::taps_t                      taps,
  input  logic [c2dsp_pkg::VALUE_W-1:0]         bias,
  output logic                                  pop,
  output logic                                  busy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [c2dsp_pkg::SUM_W-1:0]    sum,
  output logic [c2dsp_pkg::ROW_W-1:0]           out_row,
  output logic [c2dsp_pkg::COL_W-1:0]           out_col,
  output logic                                  last
);
  import c2dsp_pkg::*;

  logic       adv;
  logic       issue;
  logic [3:0] done_mask;
  logic [3:0] rem;
  logic [1:0] k;
  logic [3:0] kbit;
  logic       job_done;

  logic [ROW_W-1:0] oy;
  logic [COL_W-1:0] ox;
  meta_t            meta0;

  logic signed [PROD_W-1:0] prod_next [TAPS];

  logic                     s1v;
  logic signed [PROD_W-1:0] s1_prod [TAPS];
  meta_t                    s1_meta;

  logic                     s2v;
  logic signed [PSUM_W-1:0] s2_psum [3];
  logic [SUM_W-1:0]         s2_rd;
  meta_t                    s2_meta;

  logic                     s3v;
  logic signed [WSUM_W-1:0] s3_wsum;
  logic [SUM_W-1:0]         s3_rd;
  meta_t                    s3_meta;

  logic [SUM_W-1:0]      acc_rd;
  logic                  hist_v    [3];
  logic [ACC_ADDR_W-1:0] hist_addr [3];
  logic [SUM_W-1:0]      hist_data [3];

  logic signed [SUM_W-1:0] base_mem;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W:0]   total;
  logic signed [SUM_W-1:0] sat;

  // the whole back end holds while a result waits at the output
  assign adv   = !(out_valid && out_stall);
  assign issue = adv && (q_count != '0);
  assign rem   = head.omask & ~done_mask;

  always_comb begin
    if (rem[0]) begin
      k = 2'd0;
    end else if (rem[1]) begin
      k = 2'd1;
    end else if (rem[2]) begin
      k = 2'd2;
    end else begin
      k = 2'd3;
    end
  end

  assign kbit     = 4'b0001 << k;
  assign job_done = (rem & ~kbit) == '0;
  assign pop      = issue && job_done;

  assign oy = k[1] ? head.row : head.row - 1'b1;
  assign ox = k[0] ? head.col : head.col - 1'b1;

  assign meta0.addr  = {oy, ox};
  assign meta0.row   = oy;
  assign meta0.col   = ox;
  assign meta0.first = head.first;
  assign meta0.emit  = head.emit;
  assign meta0.last  = head.last && (k == 2'd3);

  // nine lanes, each picks its window pixel for this output and multiplies
  always_comb begin : lane_mux
    logic [1:0]               ii;
    logic [1:0]               jj;
    logic                     ok;
    logic [PIX_W-1:0]         opnd;
    logic signed [PROD_W-1:0] ta;
    logic signed [PROD_W-1:0] oa;
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        ii   = 2'(ky) + {1'b0, k[1]};
        jj   = 2'(kx) + {1'b0, k[0]};
        ok   = (ii != 2'd3) && (jj != 2'd3) &&
               !((oy == '0) && (ky == 0)) && !((ox == '0) && (kx == 0));
        opnd = '0;
        if (head.k1x1) begin
          if (ky == 0 && kx == 0) begin
            opnd = head.win[2][2];
          end
        end else if (ok) begin
          opnd = head.win[ii][jj];
        end
        ta = PROD_W'(signed'(taps[ky * 3 + kx]));
        oa = PROD_W'(signed'(opnd));
        prod_next[ky * 3 + kx] = ta * oa;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
    end else if (issue) begin
      done_mask <= job_done ? '0 : (done_mask | kbit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      s3v       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        hist_v[i] <= 1'b0;
      end
    end else if (adv) begin
      s1v       <= issue;
      s2v       <= s1v;
      s3v       <= s2v;
      out_valid <= s3v && s3_meta.emit;
      hist_v[0] <= s3v;
      hist_v[1] <= hist_v[0];
      hist_v[2] <= hist_v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod <= prod_next;
      s1_meta <= meta0;
      for (int g = 0; g < 3; g++) begin
        s2_psum[g] <= PSUM_W'(s1_prod[3 * g]) + PSUM_W'(s1_prod[3 * g + 1]) +
                      PSUM_W'(s1_prod[3 * g + 2]);
      end
      s2_rd   <= acc_rd;
      s2_meta <= s1_meta;
      s3_wsum <= WSUM_W'(s2_psum[0]) + WSUM_W'(s2_psum[1]) + WSUM_W'(s2_psum[2]);
      s3_rd   <= s2_rd;
      s3_meta <= s2_meta;
      sum     <= sat;
      out_row <= s3_meta.row;
      out_col <= s3_meta.col;
      last    <= s3_meta.last;
      hist_addr[0] <= s3_meta.addr;
      hist_data[0] <= sat;
      hist_addr[1] <= hist_addr[0];
      hist_data[1] <= hist_data[0];
      hist_addr[2] <= hist_addr[1];
      hist_data[2] <= hist_data[1];
    end
  end

  // the last three writes may be newer than what the ram returned
  always_comb begin
    if (hist_v[0] && hist_addr[0] == s3_meta.addr) begin
      base_mem = hist_data[0];
    end else if (hist_v[1] && hist_addr[1] == s3_meta.addr) begin
      base_mem = hist_data[1];
    end else if (hist_v[2] && hist_addr[2] == s3_meta.addr) begin
      base_mem = hist_data[2];
    end else begin
      base_mem = s3_rd;
    end
  end

  assign base  = s3_meta.first ? SUM_W'(signed'(bias)) : base_mem;
  assign total = (SUM_W + 1)'(base) + (SUM_W + 1)'(s3_wsum);

  always_comb begin
    if (total[SUM_W] != total[SUM_W-1]) begin
      sat = total[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sat = total[SUM_W-1:0];
    end
  end

  c2dsp_ram #(.WIDTH(SUM_W), .DEPTH(ACC_DEPTH)) u_acc (
    .clk   (clk),
    .we    (adv && s3v),
    .waddr (s3_meta.addr),
    .wdata (sat),
    .re    (issue),
    .raddr (meta0.addr),
    .rdata (acc_rd)
  );

  assign busy = s1v || s2v || s3v;

endmodule

/* hdl/conv2d_same_padding_accumulate_top.sv */
// One output channel of a multi-channel 2d convolution, 1x1 or 3x3 kernel with
// zero padding, Q4.11 inputs accumulated to a saturated 48-bit Q25.22 sum.
// Pixels are taken one per cycle. Each pixel finishes none or one output inside
// the plane, two at each row end below the first row, two on the last row except
// at its first column, four at the bottom right, and one each with the 1x1
// kernel; the back end issues one output at a time. A four-entry job queue sits
// before it, and the input stalls while the queue is full. A finishing pixel
// passes the front register, a queue slot, the back-end stages and the output
// register. Weight and bias items wait until all queued work has drained.
// depends on c2dsp_pkg, c2dsp_front, c2dsp_queue, c2dsp_back
module conv2d_same_padding_accumulate_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [c2dsp_pkg::MODE_W-1:0]         mode,
  input  logic [c2dsp_pkg::TAP_IDX_W-1:0]      tap_index,
  input  logic signed [c2dsp_pkg::VALUE_W-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [c2dsp_pkg::SUM_W-1:0]   sum,
  output logic [c2dsp_pkg::ROW_W-1:0]          out_row,
  output logic [c2dsp_pkg::COL_W-1:0]          out_col,
  output logic                                 last,
  input  logic                                 cfg_write,
  input  logic [c2dsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c2dsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import c2dsp_pkg::*;

  bstat_t             bstat;
  logic               push;
  job_t               push_job;
  logic               pop;
  job_t               head;
  logic [Q_CNT_W-1:0] q_count;
  taps_t              taps;
  logic [VALUE_W-1:0] bias;
  logic               back_busy;

  assign bstat.count = q_count;
  assign bstat.busy  = back_busy;

  c2dsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .tap_index (tap_index),
    .value     (value),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bstat     (bstat),
    .push      (push),
    .push_job  (push_job),
    .taps      (taps),
    .bias      (bias)
  );

  c2dsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  c2dsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_count   (q_count),
    .taps      (taps),
    .bias      (bias),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum       (sum),
    .out_row   (out_row),
    .out_col   (out_col),
    .last      (last)
  );

endmodule

/* hdl/c2dsp_checker.sv */
// port-level checks for the convolution top level, bound to it below
// depends on c2dsp_pkg
module c2dsp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [c2dsp_pkg::MODE_W-1:0]         mode,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [c2dsp_pkg::SUM_W-1:0]   sum,
  input logic [c2dsp_pkg::ROW_W-1:0]          out_row,
  input logic [c2dsp_pkg::COL_W-1:0]          out_col,
  input logic                                 last
);
  import c2dsp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sum) && $stable(out_row) &&
                               $stable(out_col) && $stable(last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    in_valid && (mode == MODE_NONE) |-> !in_stall)
    else $error("unused mode was stalled");

  // a pixel leaves work in flight, so weights and bias must wait
  a_drain_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_PIXEL) |=>
      !(in_valid && !in_stall && ((mode == MODE_WEIGHT) || (mode == MODE_BIAS))))
    else $error("weight or bias taken with a pixel in flight");

endmodule

bind conv2d_same_padding_accumulate_top c2dsp_checker u_checker (.*);
